// ===== rtl/core/mbd_pkg.sv =====
// Shared types and constants of the 2x2 box-filter mip downsampler.
package mbd_pkg;

  localparam int MaxSourceWidth  = 2048;
  localparam int MaxSourceHeight = 2048;
  localparam int DimW            = 12;
  localparam int PosW            = $clog2(MaxSourceWidth);
  localparam int LineDepth       = (MaxSourceWidth + 1) / 2;
  localparam int LineAw          = $clog2(LineDepth);
  localparam int NumCh           = 4;
  localparam int ChW             = 8;
  localparam int SumW            = ChW + 1;

  // Channel lanes: 0 red, 1 green, 2 blue, 3 alpha.
  typedef logic [NumCh-1:0][ChW-1:0]  texel_t;
  typedef logic [NumCh-1:0][SumW-1:0] pair_t;

  typedef enum logic {
    CFG_SOURCE_WIDTH  = 1'b0,
    CFG_SOURCE_HEIGHT = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_HALF,
    KIND_QUAD
  } kind_e;

  typedef struct packed {
    logic [ChW-1:0] red_in;
    logic [ChW-1:0] green_in;
    logic [ChW-1:0] blue_in;
    logic [ChW-1:0] alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [ChW-1:0] red_out;
    logic [ChW-1:0] green_out;
    logic [ChW-1:0] blue_out;
    logic [ChW-1:0] alpha_out;
    logic           last_texel;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [LineAw-1:0] addr;
    pair_t             wdata;
  } ls_req_t;

  typedef struct packed {
    kind_e kind;
    logic  last;
    pair_t pair;
  } stage_t;

endpackage

// ===== rtl/core/mbd_line_store.sv =====
// Line store holding the horizontal pair sums of the even source row.
module mbd_line_store (
  input  logic              clk_i,
  input  mbd_pkg::ls_req_t  req_i,
  output mbd_pkg::pair_t    rdata_o
);

  mbd_pkg::pair_t mem [mbd_pkg::LineDepth];
  mbd_pkg::pair_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mbd_front.sv =====
// Configuration, raster position tracking, pair sums and the stage register.
module mbd_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [mbd_pkg::DimW-1:0] cfg_wdata_i,
  input  logic                    accept_i,
  input  mbd_pkg::in_item_t       in_item_i,
  input  logic                    stage_take_i,
  output mbd_pkg::ls_req_t        ls_req_o,
  output logic                    stage_valid_o,
  output mbd_pkg::stage_t         stage_o
);

  logic [mbd_pkg::DimW-1:0] width_q, height_q;
  logic [mbd_pkg::PosW-1:0] col_q, col_d, row_q, row_d;
  mbd_pkg::texel_t          acc_q;
  logic                     stage_valid_q;
  mbd_pkg::stage_t          stage_q, stage_d;

  logic [mbd_pkg::DimW-1:0] w_eff, h_eff, w_even, h_even;
  logic [mbd_pkg::DimW-1:0] col_ext, row_ext, line_pos, line_len;
  logic [mbd_pkg::DimW-1:0] col_inc, row_inc;
  logic                     single_mode, line_mode;
  logic                     hold_tex, emit, ls_we, ls_re;
  mbd_pkg::texel_t          tex;
  mbd_pkg::pair_t           pair;

  assign tex = {in_item_i.alpha_in, in_item_i.blue_in, in_item_i.green_in, in_item_i.red_in};

  always_comb begin
    // Clamp the dimensions: zero acts as one, oversize as the maximum.
    w_eff = width_q;
    if (width_q == '0) begin
      w_eff = mbd_pkg::DimW'(1);
    end else if (int'(width_q) > mbd_pkg::MaxSourceWidth) begin
      w_eff = mbd_pkg::DimW'(mbd_pkg::MaxSourceWidth);
    end
    h_eff = height_q;
    if (height_q == '0) begin
      h_eff = mbd_pkg::DimW'(1);
    end else if (int'(height_q) > mbd_pkg::MaxSourceHeight) begin
      h_eff = mbd_pkg::DimW'(mbd_pkg::MaxSourceHeight);
    end
    w_even = {w_eff[mbd_pkg::DimW-1:1], 1'b0};
    h_even = {h_eff[mbd_pkg::DimW-1:1], 1'b0};

    col_ext = mbd_pkg::DimW'(col_q);
    row_ext = mbd_pkg::DimW'(row_q);

    single_mode = (w_eff == mbd_pkg::DimW'(1)) && (h_eff == mbd_pkg::DimW'(1));
    line_mode   = !single_mode &&
                  ((w_eff == mbd_pkg::DimW'(1)) || (h_eff == mbd_pkg::DimW'(1)));
    line_pos    = (h_eff == mbd_pkg::DimW'(1)) ? col_ext : row_ext;
    line_len    = (h_eff == mbd_pkg::DimW'(1)) ? w_even : h_even;

    for (int c = 0; c < mbd_pkg::NumCh; c++) begin
      pair[c] = mbd_pkg::SumW'(acc_q[c]) + mbd_pkg::SumW'(tex[c]);
    end

    hold_tex = 1'b0;
    emit     = 1'b0;
    ls_we    = 1'b0;
    ls_re    = 1'b0;
    stage_d.kind = mbd_pkg::KIND_PASS;
    stage_d.last = 1'b0;
    stage_d.pair = pair;

    if (single_mode) begin
      emit         = 1'b1;
      stage_d.last = 1'b1;
      for (int c = 0; c < mbd_pkg::NumCh; c++) begin
        stage_d.pair[c] = mbd_pkg::SumW'(tex[c]);
      end
    end else if (line_mode) begin
      if (line_pos < line_len) begin
        if (!line_pos[0]) begin
          hold_tex = 1'b1;
        end else begin
          emit         = 1'b1;
          stage_d.kind = mbd_pkg::KIND_HALF;
          stage_d.last = (line_pos == line_len - mbd_pkg::DimW'(1));
        end
      end
    end else if ((col_ext < w_even) && (row_ext < h_even)) begin
      if (!col_q[0]) begin
        hold_tex = 1'b1;
      end else if (!row_q[0]) begin
        ls_we = 1'b1;
      end else begin
        ls_re        = 1'b1;
        emit         = 1'b1;
        stage_d.kind = mbd_pkg::KIND_QUAD;
        stage_d.last = (row_ext == h_even - mbd_pkg::DimW'(1)) &&
                       (col_ext == w_even - mbd_pkg::DimW'(1));
      end
    end

    // Advance the raster position, wrapping at the end of the level.
    col_inc = col_ext + mbd_pkg::DimW'(1);
    row_inc = row_ext + mbd_pkg::DimW'(1);
    col_d   = col_inc[mbd_pkg::PosW-1:0];
    row_d   = row_q;
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= h_eff) ? '0 : row_inc[mbd_pkg::PosW-1:0];
    end
  end

  assign ls_req_o.we    = accept_i & ls_we;
  assign ls_req_o.re    = accept_i & ls_re;
  assign ls_req_o.addr  = col_q[mbd_pkg::PosW-1:1];
  assign ls_req_o.wdata = pair;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q       <= mbd_pkg::DimW'(1);
      height_q      <= mbd_pkg::DimW'(1);
      col_q         <= '0;
      row_q         <= '0;
      acc_q         <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          mbd_pkg::CFG_SOURCE_WIDTH:  width_q  <= cfg_wdata_i;
          mbd_pkg::CFG_SOURCE_HEIGHT: height_q <= cfg_wdata_i;
          default: ;
        endcase
        col_q <= '0;
        row_q <= '0;
        acc_q <= '0;
      end else if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
        if (hold_tex) begin
          acc_q <= tex;
        end
      end
      if (accept_i && emit) begin
        stage_valid_q <= 1'b1;
      end else if (stage_take_i) begin
        stage_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && emit) begin
      stage_q <= stage_d;
    end
  end

  assign stage_valid_o = stage_valid_q;
  assign stage_o       = stage_q;

endmodule

// ===== rtl/core/mbd_output.sv =====
// Final averaging and the result register.
module mbd_output (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               stage_valid_i,
  input  mbd_pkg::stage_t    stage_i,
  input  mbd_pkg::pair_t     above_i,
  input  logic               out_ready_i,
  output logic               free_o,
  output logic               out_valid_o,
  output mbd_pkg::out_item_t out_item_o
);

  logic               out_valid_q;
  mbd_pkg::out_item_t out_item_q, out_item_d;
  mbd_pkg::texel_t    avg;
  logic [mbd_pkg::SumW:0] quad;
  logic               take;

  always_comb begin
    for (int c = 0; c < mbd_pkg::NumCh; c++) begin
      quad = (mbd_pkg::SumW+1)'(above_i[c]) + (mbd_pkg::SumW+1)'(stage_i.pair[c]);
      case (stage_i.kind)
        mbd_pkg::KIND_HALF: avg[c] = stage_i.pair[c][mbd_pkg::SumW-1:1];
        mbd_pkg::KIND_QUAD: avg[c] = quad[mbd_pkg::SumW:2];
        default:            avg[c] = stage_i.pair[c][mbd_pkg::ChW-1:0];
      endcase
    end
    out_item_d.red_out    = avg[0];
    out_item_d.green_out  = avg[1];
    out_item_d.blue_out   = avg[2];
    out_item_d.alpha_out  = avg[3];
    out_item_d.last_texel = stage_i.last;
  end

  assign free_o = !out_valid_q || out_ready_i;
  assign take   = stage_valid_i && free_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/core/mipmap_box_downsample_2x2.sv =====
// Top level of the 2x2 box-filter mip level downsampler.
//
//   port group   direction  handshake            payload
//   in_*         in         in_valid/in_ready    in_item (RGBA source texel)
//   out_*        out        out_valid/out_ready  out_item (averaged texel, last flag)
//   cfg_*        in         cfg_we (no wait)     cfg_index, cfg_wdata (12 bits)
//
// One item per cycle sustained while the output is not stalled. Accepting
// an item advances the position, holds an even-column texel, writes or reads
// the line store and loads any result into the stage register; the result
// register takes its average once free. The single-port line store (at most
// one access per item) sets the per-cycle pace. Reset clears the position,
// pair holder and valid flags; the line store is not cleared and is always
// written on an even row before the odd row reads it. A stalled output holds
// the result; the stage register still takes one more result, and the input
// keeps taking items until it does, then stalls until the result register drains.
module mipmap_box_downsample_2x2 (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [mbd_pkg::DimW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  mbd_pkg::in_item_t        in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output mbd_pkg::out_item_t       out_item_o
);

  mbd_pkg::ls_req_t ls_req;
  mbd_pkg::pair_t   above;
  mbd_pkg::stage_t  stage;
  logic             stage_valid;
  logic             out_free;
  logic             accept;
  logic             stage_take;

  // Accept whenever the stage register is empty or drains this cycle.
  assign in_ready_o = !stage_valid || out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign stage_take = stage_valid && out_free;

  mbd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .in_item_i     (in_item_i),
    .stage_take_i  (stage_take),
    .ls_req_o      (ls_req),
    .stage_valid_o (stage_valid),
    .stage_o       (stage)
  );

  // Read data stays put while the stage holds: reads happen only on accept.
  mbd_line_store u_line_store (
    .clk_i   (clk_i),
    .req_i   (ls_req),
    .rdata_o (above)
  );

  mbd_output u_output (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_valid_i (stage_valid),
    .stage_i       (stage),
    .above_i       (above),
    .out_ready_i   (out_ready_i),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .out_item_o    (out_item_o)
  );

endmodule

// ===== test/mbd_texel_checker.sv =====
// Checker for the 2x2 box-filter mip downsampler: predicts and compares output texels.
module mbd_texel_checker
  import mbd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [DimW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  in_item_t         in_item_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  out_item_t        out_item_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DimW-1:0] src_width;
  logic [DimW-1:0] src_height;
  int unsigned col_pos;
  int unsigned row_pos;
  bit [NumCh-1:0][SumW-1:0] held_texel;
  bit [NumCh-1:0][SumW-1:0] even_row_sums [LineDepth];

  out_item_t expected_texels [$];
  int outstanding = 0;
  int mismatches = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Work out the output texel, if any, caused by one source texel, then step
  // the raster position.
  task automatic downsample_texel(input in_item_t t);
    int unsigned w, h, w_even, h_even, pos, len, idx;
    int unsigned avg [NumCh];
    bit [NumCh-1:0][ChW-1:0]  tex;
    bit [NumCh-1:0][SumW-1:0] pair;
    bit emit, last;
    out_item_t r;
    tex  = {t.alpha_in, t.blue_in, t.green_in, t.red_in};
    emit = 1'b0;
    last = 1'b0;
    w = (src_width == '0) ? 1 : 32'(src_width);
    if (w > MaxSourceWidth) w = MaxSourceWidth;
    h = (src_height == '0) ? 1 : 32'(src_height);
    if (h > MaxSourceHeight) h = MaxSourceHeight;
    w_even = w & 32'hFFFF_FFFE;
    h_even = h & 32'hFFFF_FFFE;

    if (w == 1 && h == 1) begin
      for (int c = 0; c < NumCh; c++) avg[c] = 32'(tex[c]);
      last = 1'b1;
      emit = 1'b1;
    end else if (w == 1 || h == 1) begin
      pos = (h == 1) ? col_pos : row_pos;
      len = (h == 1) ? w_even : h_even;
      if (pos < len) begin
        if (!pos[0]) begin
          for (int c = 0; c < NumCh; c++) held_texel[c] = SumW'(tex[c]);
        end else begin
          for (int c = 0; c < NumCh; c++) begin
            avg[c] = (32'(held_texel[c]) + 32'(tex[c])) >> 1;
          end
          last = (pos == len - 1);
          emit = 1'b1;
        end
      end
    end else if (col_pos < w_even && row_pos < h_even) begin
      if (!col_pos[0]) begin
        for (int c = 0; c < NumCh; c++) held_texel[c] = SumW'(tex[c]);
      end else begin
        idx = col_pos >> 1;
        for (int c = 0; c < NumCh; c++) pair[c] = held_texel[c] + SumW'(tex[c]);
        if (idx < LineDepth) begin
          if (!row_pos[0]) begin
            even_row_sums[idx[LineAw-1:0]] = pair;
          end else begin
            for (int c = 0; c < NumCh; c++) begin
              avg[c] = (32'(even_row_sums[idx[LineAw-1:0]][c]) + 32'(pair[c])) >> 2;
            end
            last = (row_pos == h_even - 1) && (col_pos == w_even - 1);
            emit = 1'b1;
          end
        end
      end
    end

    if (emit) begin
      r.red_out    = ChW'(avg[0]);
      r.green_out  = ChW'(avg[1]);
      r.blue_out   = ChW'(avg[2]);
      r.alpha_out  = ChW'(avg[3]);
      r.last_texel = last;
      expected_texels.push_back(r);
      outstanding++;
    end

    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      src_width  = DimW'(1);
      src_height = DimW'(1);
      col_pos    = 0;
      row_pos    = 0;
      held_texel = '0;
      expected_texels.delete();
      outstanding = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SOURCE_WIDTH) src_width = cfg_wdata_i;
        else src_height = cfg_wdata_i;
        col_pos    = 0;
        row_pos    = 0;
        held_texel = '0;
      end
      if (out_valid_i && out_ready_i) begin
        if (outstanding == 0) begin
          $display("%0t ns: output texel with none expected, actual %0h", $time, out_item_i);
          mismatches++;
        end else begin
          want = expected_texels.pop_front();
          outstanding--;
          check_field("red_out", 32'(want.red_out), 32'(out_item_i.red_out));
          check_field("green_out", 32'(want.green_out), 32'(out_item_i.green_out));
          check_field("blue_out", 32'(want.blue_out), 32'(out_item_i.blue_out));
          check_field("alpha_out", 32'(want.alpha_out), 32'(out_item_i.alpha_out));
          check_field("last_texel", 32'(want.last_texel), 32'(out_item_i.last_texel));
        end
      end
      if (in_valid_i && in_ready_i) downsample_texel(in_item_i);
    end
  end

endmodule

// ===== test/mipmap_box_downsample_2x2_tb.sv =====
// Testbench top for the 2x2 box-filter mip downsampler: stimulus, idling and verdict.
module mipmap_box_downsample_2x2_tb;
  import mbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Length of the deliberate output hold-off, in cycles.
  localparam int HoldCycles = 60;
  // Settle time after the last expected texel: covers the two-stage pipeline
  // plus any texel still in flight that gives no output.
  localparam int DrainCycles = 6;
  // Texels fed through random levels, keeping the whole run near 950 texels.
  localparam int RandomItems = 640;
  // Dimension values for random levels: zero, odd sizes and powers of two.
  localparam int unsigned DimChoices [10] = '{0, 1, 2, 3, 4, 5, 8, 16, 32, 64};

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic            cfg_index_i;
  logic [DimW-1:0] cfg_wdata_i;
  logic            in_valid_i;
  logic            in_ready_o;
  in_item_t        in_item_i;
  logic            out_valid_o;
  logic            out_ready_i;
  out_item_t       out_item_o;

  int  fail_count;
  int  pending;
  bit  idle_on;
  bit  hold_request;

  mipmap_box_downsample_2x2 u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  mbd_texel_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Output side: drop ready at random while idling is on, or hold it off for a
  // long stretch on request so that the pipeline fills and back-pressures the input.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_request = 1'b0;
      end else begin
        out_ready_i <= !(idle_on && $urandom_range(99) < 17);
      end
    end
  end

  function automatic in_item_t rgba(input int r, input int g, input int b, input int a);
    in_item_t t;
    t.red_in   = ChW'(r);
    t.green_in = ChW'(g);
    t.blue_in  = ChW'(b);
    t.alpha_in = ChW'(a);
    return t;
  endfunction

  // Size the block actually uses for a register value.
  function automatic int unsigned used_dim(input int unsigned v);
    if (v == 0) return 1;
    if (v > MaxSourceWidth) return MaxSourceWidth;
    return v;
  endfunction

  // Offer one texel and hold it until accepted; valid stays high on return
  // so that back-to-back texels never drop it.
  task automatic send_texel(input in_item_t t);
    if (idle_on) begin
      while ($urandom_range(99) < 17) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_item_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_texel(in_item_t'($urandom));
  endtask

  // Stop offering and wait until every expected texel has come out, then let
  // the pipeline empty of texels that give no output.
  task automatic drain();
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input int unsigned v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= DimW'(v);
    @(negedge clk_i);
  endtask

  // Start a new level: drain, then write both dimensions in random order.
  task automatic set_level(input int unsigned w, input int unsigned h);
    drain();
    if ($urandom_range(1)) begin
      write_reg(CFG_SOURCE_WIDTH, w);
      write_reg(CFG_SOURCE_HEIGHT, h);
    end else begin
      write_reg(CFG_SOURCE_HEIGHT, h);
      write_reg(CFG_SOURCE_WIDTH, w);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned w, h, area;
    int n, fed;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_SOURCE_WIDTH;
    cfg_wdata_i  = '0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    rst_ni       = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset size is 1x1: each texel passes straight through, flagged last.
    send_texel(rgba(0, 0, 0, 0));
    send_texel(rgba(255, 255, 255, 255));

    // 2x2 at full scale, then a second level right after the position wraps;
    // the second one checks truncation of the four-texel sum.
    set_level(2, 2);
    repeat (4) send_texel(rgba(255, 255, 255, 255));
    send_texel(rgba(1, 2, 3, 0));
    send_texel(rgba(0, 1, 0, 255));
    send_texel(rgba(0, 0, 0, 255));
    send_texel(rgba(2, 0, 0, 255));

    // Zero dimensions behave as 1x1.
    set_level(0, 0);
    send_texel(rgba(8'hA5, 8'h5A, 8'h0F, 8'hF0));

    // One row: horizontal pair averages.
    set_level(4, 1);
    send_texel(rgba(255, 0, 1, 128));
    send_texel(rgba(254, 0, 0, 127));
    send_texel(rgba(0, 255, 7, 1));
    send_texel(rgba(255, 255, 8, 0));

    // One column of odd height: the trailing row is swallowed.
    set_level(1, 3);
    send_random(3);

    // Odd width: the trailing column of each row is swallowed.
    set_level(3, 2);
    send_random(6);

    // Back-pressure: hold the output off while texels keep coming.
    set_level(16, 4);
    idle_on      = 1'b0;
    hold_request = 1'b1;
    send_random(2 * 16 * 4);

    // Oversize width clamps to the maximum; the start of the even row only.
    // No idling here, for a long unbroken stretch.
    set_level(4095, 2);
    send_random(96);

    // Oversize height clamps to the maximum; the start of the column only.
    idle_on = 1'b1;
    set_level(1, 4095);
    send_random(64);

    // Random levels, mostly whole ones, some cut short.
    fed = 0;
    while (fed < RandomItems) begin
      w = DimChoices[$urandom_range(9)];
      do h = DimChoices[$urandom_range(9)]; while (used_dim(w) * used_dim(h) > 256);
      area = used_dim(w) * used_dim(h);
      n = $urandom_range(1, 2) * area;
      if ($urandom_range(7) == 0) n = $urandom_range(1, area);
      if (n > RandomItems - fed) n = RandomItems - fed;
      idle_on = ($urandom_range(9) != 0);
      set_level(w, h);
      send_random(n);
      fed += n;
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
